// File: sv/lcm_pkg.sv
// Package: working width, counter width and the request/response structs of the shared units.
`default_nettype none
package lcm_pkg;

    // Working width of the arithmetic; operands are taken modulo 2^DATA_WIDTH
    localparam int DATA_WIDTH = 32;
    // Width of the operand and result fields on the stream ports
    localparam int FIELD_W    = 32;
    // Step counter width of the iterative units
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_resp_t;

    typedef struct packed {
        logic  start;
        word_t multiplicand;
        word_t multiplier;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic [2*DATA_WIDTH-1:0] product;
    } mul_resp_t;

endpackage
`default_nettype wire

// File: sv/lcm_div.sv
// Restoring divider, one quotient bit per cycle, shared by all remainder and quotient steps.
`default_nettype none
module lcm_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lcm_pkg::div_req_t req,
    output lcm_pkg::div_resp_t     resp
);
    import lcm_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            quo_reg, quo_next;
    word_t            dvs_reg, dvs_next;

    logic [DATA_WIDTH:0] shifted;
    logic [DATA_WIDTH:0] diff;

    // Trial subtraction of the divisor from the partial remainder
    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Load on start, then shift one bit in per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[DATA_WIDTH]) begin
                rem_next = diff[DATA_WIDTH-1:0];
            end else begin
                rem_next = shifted[DATA_WIDTH-1:0];
            end
            quo_next = {quo_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule
`default_nettype wire

// File: sv/lcm_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, full double-width product.
`default_nettype none
module lcm_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lcm_pkg::mul_req_t req,
    output lcm_pkg::mul_resp_t     resp
);
    import lcm_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            hi_reg, hi_next;
    word_t            lo_reg, lo_next;
    word_t            mcd_reg, mcd_next;

    logic [DATA_WIDTH:0] sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcd_reg} : '0);

    // Load on start, then shift the accumulator right once per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mcd_next  = mcd_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = req.multiplier;
            mcd_next  = req.multiplicand;
        end else if (busy_reg) begin
            hi_next  = sum[DATA_WIDTH:1];
            lo_next  = {sum[0], lo_reg[DATA_WIDTH-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mcd_reg <= mcd_next;
    end

    assign resp.done    = done_reg;
    assign resp.product = {hi_reg, lo_reg};

endmodule
`default_nettype wire

// File: sv/lcm_u32_overflow_zero_core.sv
// Least common multiple of two unsigned words; zero on a zero operand or on overflow.
//
// Input channel s_*: one item carries both operands; s_tready is high only while the
// core is idle. Output channel m_*: one item carries the multiple, zero when either
// operand is zero or when the product does not fit in the working width.
// The greatest common divisor is found by Euclid's remainder steps on one shared
// restoring divider (one bit per cycle); the same divider then gives a / gcd and a
// shift-and-add multiplier forms (a / gcd) * b, whose upper half flags overflow.
// Sequence: k remainder steps (k up to 46 for 32-bit operands), then the quotient,
// then the multiply, each started by a registered start pulse to its unit; m_tvalid
// rises once the multiply is done. With a zero operand m_tvalid rises at the
// accepting edge itself, so the result can be taken in the following cycle.
// The core takes no new item until its result has been delivered and it is idle
// again; its processing time is set mostly by the divider's bit-serial loop.
// Reset: aresetn (synchronous, active low) returns the core to idle and drops
// any item in flight. A stalled receiver holds m_tvalid and m_tdata steady.
`default_nettype none
module lcm_u32_overflow_zero_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] first_operand, [63:32] second_operand
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] multiple
    output logic [31:0]      m_tdata
);
    import lcm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_QUOT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic         div_start_reg, div_start_next;
    logic         mul_start_reg, mul_start_next;
    word_t        a_reg, a_next;
    word_t        b_reg, b_next;
    word_t        y_reg, y_next;
    word_t        dvd_reg, dvd_next;
    word_t        dvs_reg, dvs_next;
    logic [FIELD_W-1:0] res_reg, res_next;

    div_req_t  div_req;
    div_resp_t div_resp;
    mul_req_t  mul_req;
    mul_resp_t mul_resp;

    word_t a_in;
    word_t b_in;

    // Take the operands modulo the working width
    assign a_in = DATA_WIDTH'(s_tdata[FIELD_W-1:0]);
    assign b_in = DATA_WIDTH'(s_tdata[2*FIELD_W-1:FIELD_W]);

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dvs_reg;

    assign mul_req.start        = mul_start_reg;
    assign mul_req.multiplicand = div_resp.quotient;
    assign mul_req.multiplier   = b_reg;

    lcm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    lcm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .resp    (mul_resp)
    );

    // Sequencer: remainder steps, quotient, multiply, hold result
    always_comb begin
        state_next     = state_reg;
        div_start_next = 1'b0;
        mul_start_next = 1'b0;
        a_next         = a_reg;
        b_next         = b_reg;
        y_next         = y_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        res_next       = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    a_next = a_in;
                    b_next = b_in;
                    if (a_in == '0 || b_in == '0) begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        y_next         = b_in;
                        dvd_next       = a_in;
                        dvs_next       = b_in;
                        div_start_next = 1'b1;
                        state_next     = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                if (div_resp.done) begin
                    div_start_next = 1'b1;
                    if (div_resp.remainder == '0) begin
                        // y is the divisor: divide a by it
                        dvd_next   = a_reg;
                        dvs_next   = y_reg;
                        state_next = ST_QUOT;
                    end else begin
                        dvd_next = y_reg;
                        dvs_next = div_resp.remainder;
                        y_next   = div_resp.remainder;
                    end
                end
            end
            ST_QUOT: begin
                if (div_resp.done) begin
                    mul_start_next = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_resp.done) begin
                    // Any bit above the working width means overflow
                    if (mul_resp.product[2*DATA_WIDTH-1:DATA_WIDTH] != '0) begin
                        res_next = '0;
                    end else begin
                        res_next = FIELD_W'(mul_resp.product[DATA_WIDTH-1:0]);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            mul_start_reg <= mul_start_next;
        end
    end

    // Operands and result
    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        y_reg   <= y_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        res_reg <= res_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = res_reg;

endmodule
`default_nettype wire
